[hw/rtl/gcni_pkg.sv]
`timescale 1ns / 1ps

package gcni_pkg;

  localparam int KIND_W     = 2;
  localparam int POS_W      = 16;
  localparam int IDX_W      = 20;
  localparam int REACH_W    = 2;
  localparam int CNT_W      = 11;
  localparam int SIZE_W     = 16;
  localparam int AREA_W     = 2 * CNT_W;
  localparam int PROD_W     = 3 * CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int AXES       = 3;

  localparam logic [PROD_W-1:0] MAX_CELLS = PROD_W'(100 * 100 * 100);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOCATE     = 2'd0,
    KIND_REGION_IDX = 2'd1,
    KIND_REGION_POS = 2'd2,
    KIND_BAD        = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS_X   = 2'd0,
    CFG_CELLS_Y   = 2'd1,
    CFG_CELLS_Z   = 2'd2,
    CFG_CELL_SIZE = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOT1,
    S_TOT2,
    S_CHECK,
    S_DIV,
    S_CLAMP,
    S_BASE1,
    S_BASE2,
    S_BASE3,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [IDX_W-1:0]   cell_index;
    logic [REACH_W-1:0] reach;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_res;
    logic             error;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/gcni_ifs.sv]
`timescale 1ns / 1ps

interface gcni_in_if;
  logic          valid;
  logic          ready;
  gcni_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gcni_out_if;
  logic           valid;
  logic           ready;
  gcni_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gcni_cfg_if;
  logic           valid;
  logic           ready;
  logic [gcni_pkg::CFG_IDX_W-1:0]  index;
  logic [gcni_pkg::CFG_DATA_W-1:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

[hw/rtl/gcni_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module gcni_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gcni_pkg::IDX_W-1:0]    dividend_i,
  input  logic [gcni_pkg::SIZE_W-1:0]   divisor_i,
  output logic [gcni_pkg::IDX_W-1:0]    quotient_o,
  output logic [gcni_pkg::SIZE_W-1:0]   remainder_o,
  output gcni_pkg::div_stat_t           stat_o
);
  import gcni_pkg::*;

  localparam int StepW = $clog2(IDX_W + 1);

  logic              busy_q, done_q;
  logic [StepW-1:0]  cnt_q;
  logic [IDX_W-1:0]  quo_q;
  logic [SIZE_W-1:0] rem_q, dvs_q;
  logic [SIZE_W:0]   rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[IDX_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= StepW'(IDX_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      quo_q <= {quo_q[IDX_W-2:0], ge};
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[hw/rtl/grid_cell_neighbourhood_indexer_top.sv]
`timescale 1ns / 1ps

// Uniform-grid cell indexer with neighbor-box enumeration.
// Channels: cfg_i writes cells_x (0), cells_y (1), cells_z (2), cell_size (3);
// in_i takes one request beat (kind, positions, cell_index, reach); out_o
// returns one or more result beats, the final one flagged by last.
// Kind 0 locates a position, kind 1 enumerates the box around a cell index,
// kind 2 locates and then enumerates. Bad grid, bad kind or out-of-grid input
// gives one error beat (cell_res 0, error 1, last 1).
// Timing: in_i.ready is high only while the sequencer is idle. Per request:
// the grid total (two passes through the shared 22x11 multiplier), then
// the divisions in the shared radix-2 divider (DIMS divisions for kinds
// 0/2; 1 in 2D or 2 in 3D for kind 1), clamp and base address (S_CLAMP,
// S_BASE1 to S_BASE3), then one result beat per cycle while the receiver
// accepts them. The results go through an output register: a stalled
// receiver holds the current beat and pauses enumeration; the sequencer
// may take a new request while the last beat still waits.
// Reset: config returns to 64 x 64 x 1 cells of size 80, sequencer idle.
module grid_cell_neighbourhood_indexer_top #(
  parameter int DIMS       = 2,
  parameter int MAX_REACH  = 3,
  parameter int INDEX_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcni_cfg_if.sink   cfg_i,
  gcni_in_if.sink    in_i,
  gcni_out_if.source out_o
);
  import gcni_pkg::*;

  localparam logic [REACH_W-1:0] ReachLim   = REACH_W'((DIMS >= 3) ? 1 : MAX_REACH);
  localparam logic [PROD_W-1:0]  IndexLimit = PROD_W'(1 << INDEX_BITS);
  localparam logic [1:0]         LastLocDiv = 2'(DIMS - 1);

  // ---------------- configuration registers ----------------
  logic [CNT_W-1:0]  cells_x_q, cells_y_q, cells_z_q;
  logic [SIZE_W-1:0] cell_size_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q   <= CNT_W'(64);
      cells_y_q   <= CNT_W'(64);
      cells_z_q   <= CNT_W'(1);
      cell_size_q <= SIZE_W'(80);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_CELLS_X:   cells_x_q   <= cfg_i.value[CNT_W-1:0];
        CFG_CELLS_Y:   cells_y_q   <= cfg_i.value[CNT_W-1:0];
        CFG_CELLS_Z:   cells_z_q   <= cfg_i.value[CNT_W-1:0];
        CFG_CELL_SIZE: cell_size_q <= cfg_i.value[SIZE_W-1:0];
      endcase
    end
  end

  // z extent collapses to one cell in 2D
  logic [CNT_W-1:0] dim [AXES];
  assign dim[0] = cells_x_q;
  assign dim[1] = cells_y_q;
  assign dim[2] = (DIMS >= 3) ? cells_z_q : CNT_W'(1);

  // ---------------- state ----------------
  state_e state_q, state_d;

  kind_e             kind_q;
  logic [POS_W-1:0]  pos_q [AXES];
  logic [IDX_W-1:0]  idx_q;
  logic [REACH_W-1:0] reach_q;
  logic [1:0]        div_n_q;
  logic [CNT_W-1:0]  c_q  [AXES];
  logic [CNT_W-1:0]  lo_q [AXES];
  logic [CNT_W-1:0]  hi_q [AXES];
  logic [CNT_W-1:0]  lo_d [AXES];
  logic [CNT_W-1:0]  hi_d [AXES];
  logic [CNT_W-1:0]  x_q, y_q, z_q;
  logic [AREA_W-1:0] cxy_q;
  logic [IDX_W-1:0]  ycx_q, row_q, plane_q;

  // shared multiplier, registered product
  logic [AREA_W-1:0] mul_a;
  logic [CNT_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p, mul_q;
  assign mul_p = mul_a * mul_b;
  always_ff @(posedge clk_i) mul_q <= mul_p;

  // shared divider
  logic              div_start;
  logic [IDX_W-1:0]  div_dvd, div_quo;
  logic [SIZE_W-1:0] div_dvs, div_rem;
  div_stat_t         div_stat;

  gcni_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .stat_o     (div_stat)
  );

  // output register
  logic out_valid_q, out_free, out_load;
  out_t out_data_q, out_nxt;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------- decisions ----------------
  logic in_acc, usable, check_err, last_div, loc_bad, emit_last, by_idx;
  logic [REACH_W-1:0] reach_in;

  assign in_acc   = in_i.valid && in_i.ready;
  assign by_idx   = (kind_q == KIND_REGION_IDX);
  // locate behaves as a region of reach zero: one beat flagged last
  assign reach_in = (kind_e'(in_i.data.kind) == KIND_LOCATE) ? '0 :
                    (in_i.data.reach > ReachLim) ? ReachLim : in_i.data.reach;

  // mul_q holds the cell total while in S_CHECK; zero total means a zero axis
  assign usable    = (mul_q != '0) && (mul_q <= MAX_CELLS) && (mul_q <= IndexLimit);
  assign check_err = !usable || (kind_q == KIND_BAD) ||
                     (by_idx ? (PROD_W'(idx_q) >= mul_q) : (cell_size_q == '0));
  assign last_div  = by_idx ? ((DIMS < 3) || (div_n_q == 2'd1)) : (div_n_q == LastLocDiv);
  assign loc_bad   = !by_idx && (div_quo >= IDX_W'(dim[div_n_q]));
  assign emit_last = (x_q == hi_q[0]) && (y_q == hi_q[1]) && (z_q == hi_q[2]);

  always_comb begin
    logic [CNT_W:0] sum;
    for (int j = 0; j < AXES; j++) begin
      sum     = {1'b0, c_q[j]} + (CNT_W + 1)'(reach_q);
      lo_d[j] = (c_q[j] >= CNT_W'(reach_q)) ? c_q[j] - CNT_W'(reach_q) : '0;
      hi_d[j] = (sum < {1'b0, dim[j]}) ? sum[CNT_W-1:0] : dim[j] - CNT_W'(1);
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_TOT1;
      S_TOT1:  state_d = S_TOT2;
      S_TOT2:  state_d = S_CHECK;
      S_CHECK: state_d = check_err ? S_ERR : S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          if (loc_bad)       state_d = S_ERR;
          else if (last_div) state_d = S_CLAMP;
        end
      end
      S_CLAMP: state_d = S_BASE1;
      S_BASE1: state_d = S_BASE2;
      S_BASE2: state_d = S_BASE3;
      S_BASE3: state_d = S_EMIT;
      S_EMIT:  if (out_free && emit_last) state_d = S_IDLE;
      S_ERR:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_i.ready = (state_q == S_IDLE);
    mul_a      = AREA_W'(cells_x_q);
    mul_b      = cells_y_q;
    div_start  = 1'b0;
    div_dvd    = idx_q;
    div_dvs    = SIZE_W'(cells_x_q);
    out_load   = 1'b0;
    out_nxt    = '0;
    unique case (state_q)
      S_TOT2: begin
        mul_a = mul_q[AREA_W-1:0];
        mul_b = dim[2];
      end
      S_CHECK: begin
        div_start = !check_err;
        div_dvd   = by_idx ? idx_q : IDX_W'(pos_q[0]);
        div_dvs   = by_idx ? SIZE_W'(cells_x_q) : cell_size_q;
      end
      S_DIV: begin
        div_start = div_stat.done && !loc_bad && !last_div;
        div_dvd   = by_idx ? div_quo : IDX_W'(pos_q[div_n_q + 2'd1]);
        div_dvs   = by_idx ? SIZE_W'(cells_y_q) : cell_size_q;
      end
      S_BASE1: begin
        mul_a = AREA_W'(cells_x_q);
        mul_b = lo_q[1];
      end
      S_BASE2: begin
        mul_a = cxy_q;
        mul_b = lo_q[2];
      end
      S_EMIT: begin
        out_load         = out_free;
        out_nxt.cell_res = IDX_W'(row_q + IDX_W'(x_q));
        out_nxt.last     = emit_last;
      end
      S_ERR: begin
        out_load      = out_free;
        out_nxt.error = 1'b1;
        out_nxt.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           out_valid_q <= 1'b0;
    else if (out_load)     out_valid_q <= 1'b1;
    else if (out_o.ready)  out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= out_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_n_q <= '0;
    end else if (state_q == S_CHECK) begin
      div_n_q <= '0;
    end else if (state_q == S_DIV && div_stat.done) begin
      div_n_q <= div_n_q + 2'd1;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_q   <= kind_e'(in_i.data.kind);
          pos_q[0] <= in_i.data.pos_x;
          pos_q[1] <= in_i.data.pos_y;
          pos_q[2] <= in_i.data.pos_z;
          idx_q    <= in_i.data.cell_index;
          reach_q  <= reach_in;
          for (int j = 0; j < AXES; j++) c_q[j] <= '0;
        end
      end
      S_TOT2: cxy_q <= mul_q[AREA_W-1:0];
      S_DIV: begin
        if (div_stat.done && !loc_bad) begin
          if (by_idx) begin
            if (div_n_q == 2'd0) begin
              c_q[0] <= div_rem[CNT_W-1:0];
              c_q[1] <= div_quo[CNT_W-1:0];  // final in 2D
            end else begin
              c_q[1] <= div_rem[CNT_W-1:0];
              c_q[2] <= div_quo[CNT_W-1:0];
            end
          end else begin
            c_q[div_n_q] <= div_quo[CNT_W-1:0];
          end
        end
      end
      S_CLAMP: begin
        for (int j = 0; j < AXES; j++) begin
          lo_q[j] <= lo_d[j];
          hi_q[j] <= hi_d[j];
        end
      end
      S_BASE2: ycx_q <= mul_q[IDX_W-1:0];
      S_BASE3: begin
        plane_q <= IDX_W'(mul_q[IDX_W-1:0] + ycx_q);
        row_q   <= IDX_W'(mul_q[IDX_W-1:0] + ycx_q);
        x_q     <= lo_q[0];
        y_q     <= lo_q[1];
        z_q     <= lo_q[2];
      end
      S_EMIT: begin
        if (out_free) begin
          if (x_q != hi_q[0]) begin
            x_q <= x_q + CNT_W'(1);
          end else begin
            x_q <= lo_q[0];
            if (y_q != hi_q[1]) begin
              y_q   <= y_q + CNT_W'(1);
              row_q <= IDX_W'(row_q + IDX_W'(cells_x_q));
            end else begin
              y_q <= lo_q[1];
              if (z_q != hi_q[2]) begin
                z_q     <= z_q + CNT_W'(1);
                plane_q <= IDX_W'(plane_q + cxy_q);
                row_q   <= IDX_W'(plane_q + cxy_q);
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("output beat overwritten");

  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.error) |-> (out_o.data.last && out_o.data.cell_res == '0))
    else $error("malformed error beat");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_TOT1))
    else $error("request accepted outside idle");

endmodule
